// ===== design/shabs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: shared package
// Widths, initial chaining value, round constants, byte select codes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package shabs_pkg;

	localparam int BlkCntBits = 23;
	localparam int LenBits    = BlkCntBits + 9;
	localparam int WordW      = 32;
	localparam int IdxW       = 3;
	localparam int NumWords   = 5;

	localparam logic [WordW-1:0] H0 = 32'h67452301;
	localparam logic [WordW-1:0] H1 = 32'hEFCDAB89;
	localparam logic [WordW-1:0] H2 = 32'h98BADCFE;
	localparam logic [WordW-1:0] H3 = 32'h10325476;
	localparam logic [WordW-1:0] H4 = 32'hC3D2E1F0;

	localparam logic [WordW-1:0] K0 = 32'h5A827999;
	localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [6:0] LastRound = 7'd79;
	localparam logic [5:0] LastPos   = 6'd63;
	localparam logic [5:0] LenPos    = 6'd56;
	localparam logic [IdxW-1:0] LastIdx = 3'd4;

	localparam logic REQ_DATA   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	typedef struct packed {
		logic            shift_en;
		logic [1:0]      byte_sel;
		logic            len_cap;
		logic            cnt_block;
		logic            round_init;
		logic            round_en;
		logic            chain_add;
		logic            msg_clear;
		logic [IdxW-1:0] word_idx;
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       round_last;
	} sts_t;

	function automatic logic [WordW-1:0] init_word(input logic [IdxW-1:0] idx);
		logic [WordW-1:0] r;
		case (idx)
			3'd0:    r = H0;
			3'd1:    r = H1;
			3'd2:    r = H2;
			3'd3:    r = H3;
			default: r = H4;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/shabs_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: request channel
// Valid/ready channel carrying one data byte or a finish request.
// ----------------------------------------------------------------------------
interface shabs_req_if import shabs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== design/shabs_dig_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: digest channel
// Valid/ready channel carrying one digest word per transfer.
// ----------------------------------------------------------------------------
interface shabs_dig_if import shabs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] digest_word;
	logic [IdxW-1:0]  word_index;
	logic             last_word;
	logic             too_long;

	modport source (output valid, output digest_word, output word_index,
		output last_word, output too_long, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, input too_long, output ready);
endinterface
`default_nettype wire

// ===== design/shabs_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: datapath
// 512-bit block shift register doubling as the message schedule, one
// compression round per cycle, chaining value, byte and block counters.
// ----------------------------------------------------------------------------
module shabs_dpath import shabs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [7:0]       data_byte,
	output      sts_t             sts,
	output      logic [WordW-1:0] digest_word,
	output      logic             too_long
);

	logic [511:0]            blk_q;
	logic [WordW-1:0]        chain_q [NumWords];
	logic [WordW-1:0]        a_q, b_q, c_q, d_q, e_q;
	logic [6:0]              rnd_q;
	logic [5:0]              pos_q;
	logic [BlkCntBits-1:0]   blk_cnt_q;
	logic                    limit_q;
	logic [LenBits-1:0]      len_q;

	logic [63:0]             len64;
	logic [5:0]              len_sh;
	logic [7:0]              byte_in;
	logic [WordW-1:0]        w0, w_next, f, k, t;

	assign len64  = 64'(len_q);
	assign len_sh = {~pos_q[2:0], 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = PadByte;
			SEL_ZERO: byte_in = 8'h00;
			default:  byte_in = 8'(len64 >> len_sh);
		endcase
	end

	assign w0     = blk_q[511:480];
	assign w_next = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w0;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_next[30:0], w_next[31]};
		end
		if (cmd.round_init) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.len_cap) begin
			len_q <= {blk_cnt_q, pos_q, 3'b000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) begin
				chain_q[i] <= init_word(IdxW'(i));
			end
			rnd_q     <= '0;
			pos_q     <= '0;
			blk_cnt_q <= '0;
			limit_q   <= 1'b0;
		end else begin
			if (cmd.shift_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.round_init) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.cnt_block) begin
				blk_cnt_q <= blk_cnt_q + 1'b1;
				if (&blk_cnt_q) begin
					limit_q <= 1'b1;
				end
			end
			if (cmd.msg_clear) begin
				for (int i = 0; i < NumWords; i++) begin
					chain_q[i] <= init_word(IdxW'(i));
				end
				blk_cnt_q <= '0;
				limit_q   <= 1'b0;
			end else if (cmd.chain_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

	always_comb begin
		case (cmd.word_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			default: digest_word = chain_q[4];
		endcase
	end

	assign too_long       = limit_q;
	assign sts.pos        = pos_q;
	assign sts.round_last = (rnd_q == LastRound);

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> rnd_q <= LastRound)
		else $error("round counter beyond last round");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_en && cmd.byte_sel == SEL_LEN) |-> pos_q >= LenPos)
		else $error("length byte outside length field");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.msg_clear |=> (chain_q[0] == H0 && chain_q[4] == H4 &&
			blk_cnt_q == '0 && !limit_q))
		else $error("message restart incomplete");

endmodule
`default_nettype wire

// ===== design/shabs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: controller
// Sequences byte intake, padding, block compression and digest readout.
// ----------------------------------------------------------------------------
module shabs_ctrl import shabs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_type,
	input  wire logic dig_ready,
	input  wire sts_t sts,
	output      logic req_ready,
	output      logic dig_valid,
	output      cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]      state_q, state_n;
	logic            fin_q, fin_n;
	logic            extra_q, extra_n;
	logic            last_q, last_n;
	logic [IdxW-1:0] idx_q, idx_n;

	always_comb begin
		state_n   = state_q;
		fin_n     = fin_q;
		extra_n   = extra_q;
		last_n    = last_q;
		idx_n     = idx_q;
		req_ready = 1'b0;
		dig_valid = 1'b0;
		cmd       = '0;
		cmd.byte_sel = SEL_DATA;
		cmd.word_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.shift_en = 1'b1;
					if (req_type == REQ_DATA) begin
						cmd.byte_sel = SEL_DATA;
						if (sts.pos == LastPos) begin
							cmd.cnt_block  = 1'b1;
							cmd.round_init = 1'b1;
							state_n        = ST_COMP;
						end
					end else begin
						cmd.byte_sel = SEL_PAD;
						cmd.len_cap  = 1'b1;
						fin_n        = 1'b1;
						last_n       = 1'b0;
						if (sts.pos == LastPos) begin
							cmd.round_init = 1'b1;
							extra_n        = 1'b0;
							state_n        = ST_COMP;
						end else begin
							extra_n = (sts.pos >= LenPos);
							state_n = ST_PAD;
						end
					end
				end
			end
			ST_PAD: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = (sts.pos >= LenPos && !extra_q) ? SEL_LEN : SEL_ZERO;
				if (sts.pos == LastPos) begin
					cmd.round_init = 1'b1;
					state_n        = ST_COMP;
					if (extra_q) begin
						extra_n = 1'b0;
					end else begin
						last_n = 1'b1;
					end
				end
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (sts.round_last) begin
					state_n = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
				if (last_q) begin
					idx_n   = '0;
					state_n = ST_OUT;
				end else if (fin_q) begin
					state_n = ST_PAD;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_OUT: begin
				dig_valid = 1'b1;
				if (dig_ready) begin
					if (idx_q == LastIdx) begin
						cmd.msg_clear = 1'b1;
						fin_n         = 1'b0;
						last_n        = 1'b0;
						state_n       = ST_IDLE;
					end else begin
						idx_n = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
			extra_q <= 1'b0;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			fin_q   <= fin_n;
			extra_q <= extra_n;
			last_q  <= last_n;
			idx_q   <= idx_n;
		end
	end

	a_comp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (sts.pos == '0))
		else $error("compression with partial block");

	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (idx_q <= LastIdx && fin_q && last_q))
		else $error("digest readout out of sequence");

	a_extra_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(extra_q && state_q == ST_PAD) |-> !last_q)
		else $error("final block flagged before extra block");

endmodule
`default_nettype wire

// ===== design/sha1_byte_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: top level
// Standard SHA-1 over a stream of bytes with padding and digest readout.
// ----------------------------------------------------------------------------
// A data byte is taken while idle; the 64th byte of a block makes the hasher
// busy (80 rounds in the single round unit, one chaining add) before the next.
// A finish transfer inserts the pad bytes at one a cycle (up to 64, or 72
// when an extra block is needed), each padded block compressed in turn, then gives
// the five digest words when the sink is ready.
// Reset is asynchronous: the chaining value returns to the initial vector.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher import shabs_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	shabs_req_if.sink   req,
	shabs_dig_if.source dig
);

	cmd_t cmd;
	sts_t sts;

	shabs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.dig_ready (dig.ready),
		.sts       (sts),
		.req_ready (req.ready),
		.dig_valid (dig.valid),
		.cmd       (cmd)
	);

	shabs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (req.data_byte),
		.sts         (sts),
		.digest_word (dig.digest_word),
		.too_long    (dig.too_long)
	);

	assign dig.word_index = cmd.word_idx;
	assign dig.last_word  = (cmd.word_idx == LastIdx);

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: testbench
// Feeds messages byte by byte, then a finish, through the request channel and
// checks every digest word against an in-bench SHA-1 model. Short directed
// messages come first, then random messages, some around the padding boundaries,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import shabs_pkg::*;

	localparam int NumRandomReqs = 380;
	localparam int StallLimit    = 5000;
	localparam int DrainCycles   = 100;

	typedef struct packed {
		logic       rtype;
		logic [7:0] data;
		logic       hold;
	} byte_req_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [IdxW-1:0]  idx;
		logic             last;
		logic             too_long;
	} digest_beat_t;

	typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} pace_t;

	logic clk;
	logic arst_n;

	shabs_req_if req_ch ();
	shabs_dig_if dig_ch ();

	sha1_byte_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.dig    (dig_ch)
	);

	byte_req_t    pending_reqs[$];
	digest_beat_t digest_expect[$];
	digest_beat_t want_beat;

	logic [WordW-1:0]      hash_chain [NumWords];
	logic [7:0]            msg_buf [64];
	logic [5:0]            msg_fill;
	logic [BlkCntBits-1:0] msg_blocks;
	logic                  len_overflow;

	pace_t pace;
	int    total_reqs;
	int    sent_count;
	int    results_pending;
	int    fail_count;
	int    stall_cycles;
	bit    took;

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic int idle_pct(input pace_t p, input bit source_side);
		case (p)
			PH_SLOW_SINK:   return source_side ? 24 : 77;
			PH_SLOW_SOURCE: return source_side ? 77 : 24;
			default:        return 0;
		endcase
	endfunction

	function automatic void sha1_restart();
		hash_chain[0] = H0;
		hash_chain[1] = H1;
		hash_chain[2] = H2;
		hash_chain[3] = H3;
		hash_chain[4] = H4;
		msg_fill      = '0;
		msg_blocks    = '0;
		len_overflow  = 1'b0;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		e = hash_chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = d ^ (b & (c ^ d));
				k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
		hash_chain[4] += e;
	endfunction

	function automatic void sha1_absorb(input logic rtype, input logic [7:0] data);
		logic [63:0] bit_len;
		if (rtype == REQ_DATA) begin
			msg_buf[msg_fill] = data;
			msg_fill = msg_fill + 6'd1;
			if (msg_fill == '0) begin
				sha1_compress();
				if (msg_blocks == {BlkCntBits{1'b1}})
					len_overflow = 1'b1;
				msg_blocks = msg_blocks + 1'b1;
			end
		end else begin
			bit_len = {32'd0, msg_blocks, 9'd0} + {55'd0, msg_fill, 3'd0};
			msg_buf[msg_fill] = PadByte;
			for (int i = msg_fill + 1; i < 64; i++)
				msg_buf[i] = 8'h00;
			if (msg_fill >= LenPos) begin
				sha1_compress();
				for (int i = 0; i < 64; i++)
					msg_buf[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				msg_buf[LenPos + i] = bit_len[63 - 8*i -: 8];
			sha1_compress();
			for (int i = 0; i < NumWords; i++)
				digest_expect.push_back(digest_beat_t'{
					word:     hash_chain[i],
					idx:      IdxW'(i),
					last:     (IdxW'(i) == LastIdx),
					too_long: len_overflow});
			sha1_restart();
		end
	endfunction

	function automatic void push_req(input logic rtype, input logic [7:0] data,
		input logic hold);
		pending_reqs.push_back(byte_req_t'{rtype: rtype, data: data, hold: hold});
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_type  <= REQ_DATA;
			req_ch.data_byte <= 8'h00;
			pace             <= PH_SLOW_SINK;
			sent_count       = 0;
		end else begin
			took = req_ch.valid && req_ch.ready;
			if (took) begin
				pending_reqs.delete(0);
				sent_count++;
			end
			if (sent_count < total_reqs / 3)
				pace <= PH_SLOW_SINK;
			else if (sent_count < 2 * total_reqs / 3)
				pace <= PH_SLOW_SOURCE;
			else
				pace <= PH_FREE;
			if (req_ch.valid && !took) begin
				// hold until the transfer completes
			end else if (pending_reqs.size() != 0 &&
				!(pending_reqs[0].hold && (took || results_pending != 0)) &&
				$urandom_range(99) >= idle_pct(pace, 1'b1)) begin
				req_ch.valid     <= 1'b1;
				req_ch.req_type  <= pending_reqs[0].rtype;
				req_ch.data_byte <= pending_reqs[0].data;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready    <= 1'b0;
			results_pending <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				sha1_absorb(req_ch.req_type, req_ch.data_byte);
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_expect.size() == 0) begin
					$display("%0t: unexpected digest transfer, expected none, actual %h idx %0d",
						$time, dig_ch.digest_word, dig_ch.word_index);
					fail_count++;
				end else begin
					want_beat = digest_expect.pop_front();
					check_field("digest_word", want_beat.word, dig_ch.digest_word);
					check_field("word_index", 32'(want_beat.idx), 32'(dig_ch.word_index));
					check_field("last_word", 32'(want_beat.last), 32'(dig_ch.last_word));
					check_field("too_long", 32'(want_beat.too_long), 32'(dig_ch.too_long));
				end
			end
			results_pending <= digest_expect.size();
			dig_ch.ready    <= ($urandom_range(99) >= idle_pct(pace, 1'b0));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (dig_ch.valid && dig_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("Verification failed");
				$finish;
			end
		end else begin
			stall_cycles <= 0;
		end
	end

	initial begin
		int pick, len, directed;
		logic hold;
		arst_n           = 1'b0;
		total_reqs       = 0;
		for (int i = 0; i < 64; i++)
			msg_buf[i] = 8'h00;
		sha1_restart();

		// empty messages, finish byte ignored
		push_req(REQ_FINISH, 8'hFF, 1'b0);
		push_req(REQ_FINISH, 8'h00, 1'b0);
		push_req(REQ_DATA, 8'h61, 1'b0);
		push_req(REQ_DATA, 8'h62, 1'b0);
		push_req(REQ_DATA, 8'h63, 1'b0);
		push_req(REQ_FINISH, 8'h00, 1'b0);
		push_req(REQ_DATA, 8'h00, 1'b1);
		push_req(REQ_DATA, 8'hFF, 1'b0);
		push_req(REQ_DATA, 8'h80, 1'b0);
		push_req(REQ_DATA, 8'h7F, 1'b0);
		push_req(REQ_FINISH, 8'hA5, 1'b0);
		push_req(REQ_FINISH, 8'h5A, 1'b1);
		directed = pending_reqs.size();

		while (pending_reqs.size() < directed + NumRandomReqs) begin
			pick = $urandom_range(9);
			if (pick < 4)
				len = $urandom_range(20);
			else if (pick == 4)
				len = $urandom_range(55, 65);
			else if (pick == 5)
				len = $urandom_range(119, 129);
			else
				len = $urandom_range(63);
			hold = ($urandom_range(19) == 0);
			for (int i = 0; i < len; i++) begin
				push_req(REQ_DATA, 8'($urandom_range(255)), hold);
				hold = 1'b0;
			end
			push_req(REQ_FINISH, 8'($urandom_range(255)), hold);
		end
		total_reqs = pending_reqs.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (pending_reqs.size() != 0 || digest_expect.size() != 0);
		repeat (DrainCycles) @(negedge clk);

		if (fail_count == 0 && digest_expect.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
